// File: hdl/bgsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Binary greedy slice mesher package
// Shared constants, payload structs, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package bgsm_pkg;

  localparam int CHUNK_BITS = 32;
  localparam int COL_W      = $clog2(CHUNK_BITS);
  localparam int CNT_W      = COL_W + 1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [COL_W-1:0]      column_index;
    logic [CHUNK_BITS-1:0] front_bits;
    logic [CHUNK_BITS-1:0] back_bits;
  } item_t;

  typedef struct packed {
    logic             done_res;
    logic             is_back;
    logic [COL_W-1:0] width_start;
    logic [COL_W-1:0] height_start;
    logic [CNT_W-1:0] height_len;
    logic [CNT_W-1:0] width_len;
    logic             flip_diagonal;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FIND,
    ST_RUN,
    ST_EXT,
    ST_OUT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_SCAN_NEXT,
    RD_EXT_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    wr_item;
    logic    advance;
    logic    find_latch;
    logic    run_latch;
    logic    absorb;
    logic    emit_rect;
    logic    emit_done;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic rest_zero;
    logic last_half;
    logic start_last;
    logic covers;
    logic ext_last;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/binary_greedy_slice_mesher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Binary greedy slice mesher
// Greedy rectangle extraction over one voxel slice stored as bit columns.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge where start is high and busy is low.
// A write item (mode 0) stores the front and back words of one column and
// restarts the scan; it completes in the accepting cycle and busy stays low.
// A fetch item (mode 1) raises busy until its result is produced. The result
// is presented for exactly one cycle with result_valid high; the receiver
// cannot stall it, and busy is already low during that cycle.
// A fetch visits each column half with a memory read and a run search state.
// A found run then passes the run latch state and the extension state, which
// absorbs each covered following column and checks the column that ends the
// extension unless the slice edge ends it, then the output state and the
// result register. A done answer after the scan has finished passes the done
// state and the result register. One item is handled at a time.
// The corner_light register is written over the cfg channel, which is always
// ready. Reset clears the scan position, corner_light and the strobe; column
// memory contents are undefined until written.
// ----------------------------------------------------------------------------
module binary_greedy_slice_mesher (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire bgsm_pkg::item_t   item,
  output bgsm_pkg::result_t      result,
  output logic                   result_valid,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [7:0]        cfg_data
);

  bgsm_pkg::cmd_t    cmd;
  bgsm_pkg::status_t status;

  assign cfg_ready = 1'b1;

  bgsm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (item.mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bgsm_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

  a_fetch_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.mode == bgsm_pkg::MODE_FETCH) |=> busy)
    else $error("Fetch transfer did not raise busy.");

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("Result strobe while a fetch is still running.");

  a_done_clear: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.done_res) |-> (result.width_len == '0 && result.height_len == '0))
    else $error("Done result carries a rectangle.");

  a_rect_size: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.done_res) |-> (result.width_len != '0 && result.height_len != '0))
    else $error("Rectangle result with zero extent.");

endmodule
`default_nettype wire

// File: hdl/bgsm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Binary greedy slice mesher controller
// Sequences a fetch through column reads, run search, extension over the
// following columns and the result transfer.
// ----------------------------------------------------------------------------
module bgsm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              mode,
  input  wire bgsm_pkg::status_t status,
  output bgsm_pkg::cmd_t         cmd,
  output logic                   busy
);

  bgsm_pkg::state_t state;
  bgsm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bgsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.rd_sel     = bgsm_pkg::RD_SCAN;
    busy           = 1'b1;
    case (state)
      bgsm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (mode == bgsm_pkg::MODE_WRITE) begin
            cmd.wr_item = 1'b1;
          end else if (status.scan_done) begin
            state_next = bgsm_pkg::ST_DONE;
          end else begin
            state_next = bgsm_pkg::ST_LOAD;
          end
        end
      end
      bgsm_pkg::ST_LOAD: begin
        state_next = bgsm_pkg::ST_FIND;
      end
      bgsm_pkg::ST_FIND: begin
        if (status.rest_zero) begin
          cmd.advance = 1'b1;
          state_next  = status.last_half ? bgsm_pkg::ST_DONE : bgsm_pkg::ST_LOAD;
        end else begin
          cmd.find_latch = 1'b1;
          state_next     = bgsm_pkg::ST_RUN;
        end
      end
      bgsm_pkg::ST_RUN: begin
        cmd.run_latch = 1'b1;
        cmd.rd_sel    = bgsm_pkg::RD_SCAN_NEXT;
        state_next    = status.start_last ? bgsm_pkg::ST_OUT : bgsm_pkg::ST_EXT;
      end
      bgsm_pkg::ST_EXT: begin
        if (status.covers) begin
          cmd.absorb = 1'b1;
          cmd.rd_sel = bgsm_pkg::RD_EXT_NEXT;
          state_next = status.ext_last ? bgsm_pkg::ST_OUT : bgsm_pkg::ST_EXT;
        end else begin
          state_next = bgsm_pkg::ST_OUT;
        end
      end
      bgsm_pkg::ST_OUT: begin
        cmd.emit_rect = 1'b1;
        state_next    = bgsm_pkg::ST_IDLE;
      end
      bgsm_pkg::ST_DONE: begin
        cmd.emit_done = 1'b1;
        state_next    = bgsm_pkg::ST_IDLE;
      end
      default: begin
        state_next = bgsm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/bgsm_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Binary greedy slice mesher datapath
// Holds the front and back column memories, the scan position, the run
// being extended, the corner light register and the result register.
// ----------------------------------------------------------------------------
module bgsm_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire bgsm_pkg::item_t                 item,
  input  wire bgsm_pkg::cmd_t                  cmd,
  input  wire logic                            cfg_valid,
  input  wire logic [7:0]                      cfg_data,
  output bgsm_pkg::status_t                    status,
  output bgsm_pkg::result_t                    result,
  output logic                                 result_valid
);

  localparam int CB = bgsm_pkg::CHUNK_BITS;
  localparam int CW = bgsm_pkg::COL_W;
  localparam int NW = bgsm_pkg::CNT_W;

  function automatic logic [NW-1:0] low_zeros(input logic [CB-1:0] v);
    logic [NW-1:0] n;
    logic          found;
    n     = NW'(CB);
    found = 1'b0;
    for (int i = 0; i < CB; i++) begin
      if (!found && v[i]) begin
        n     = NW'(i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  logic [CB-1:0] front_mem [CB];
  logic [CB-1:0] back_mem  [CB];
  logic [CB-1:0] front_q;
  logic [CB-1:0] back_q;
  logic [CB-1:0] rd_word;
  logic [CW-1:0] rd_addr;

  logic [NW-1:0] scan_column;
  logic          scan_side;
  logic [NW-1:0] scan_height;

  logic [7:0]    corner_light;
  logic [CW-1:0] hpos;
  logic [CB-1:0] hold;
  logic [CB-1:0] run;
  logic [NW-1:0] count;
  logic [NW-1:0] width;
  logic [CW-1:0] ext_col;

  logic [CB-1:0] rest;
  logic [CB-1:0] run_src;
  logic [CB-1:0] run_low;
  logic [NW-1:0] height_end;
  logic [CW-1:0] wr_addr;
  logic [CB-1:0] wr_front;
  logic [CB-1:0] wr_back;
  logic          we_front;
  logic          we_back;
  logic [2:0]    diag_a;
  logic [2:0]    diag_b;

  always_comb begin
    case (cmd.rd_sel)
      bgsm_pkg::RD_SCAN:      rd_addr = scan_column[CW-1:0];
      bgsm_pkg::RD_SCAN_NEXT: rd_addr = scan_column[CW-1:0] + CW'(1);
      bgsm_pkg::RD_EXT_NEXT:  rd_addr = ext_col + CW'(1);
      default:                rd_addr = scan_column[CW-1:0];
    endcase
  end

  assign rd_word = scan_side ? back_q : front_q;
  assign rest    = rd_word >> scan_height;
  assign run_src = hold >> hpos;
  assign run_low = run_src & ~(run_src + CB'(1));

  assign wr_addr  = cmd.wr_item ? item.column_index : ext_col;
  assign wr_front = cmd.wr_item ? item.front_bits : (rd_word ^ run);
  assign wr_back  = cmd.wr_item ? item.back_bits : (rd_word ^ run);
  assign we_front = cmd.wr_item || (cmd.absorb && !scan_side);
  assign we_back  = cmd.wr_item || (cmd.absorb && scan_side);

  assign height_end = NW'({1'b0, hpos}) + count;
  assign diag_a     = {1'b0, corner_light[3:2]} + {1'b0, corner_light[5:4]};
  assign diag_b     = {1'b0, corner_light[1:0]} + {1'b0, corner_light[7:6]};

  always_comb begin
    status.scan_done  = (scan_column == NW'(CB));
    status.rest_zero  = (rest == '0);
    status.last_half  = scan_side && (scan_column == NW'(CB - 1));
    status.start_last = (scan_column == NW'(CB - 1));
    status.covers     = ((rd_word & run) == run);
    status.ext_last   = (ext_col == CW'(CB - 1));
  end

  always_ff @(posedge clk) begin
    if (we_front) begin
      front_mem[wr_addr] <= wr_front;
    end
    if (we_back) begin
      back_mem[wr_addr] <= wr_back;
    end
    front_q <= front_mem[rd_addr];
    back_q  <= back_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_column  <= '0;
      scan_side    <= 1'b0;
      scan_height  <= '0;
      corner_light <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_rect || cmd.emit_done;
      if (cfg_valid) begin
        corner_light <= cfg_data;
      end
      if (cmd.wr_item) begin
        scan_column <= '0;
        scan_side   <= 1'b0;
        scan_height <= '0;
      end else if (cmd.advance || (cmd.emit_rect && height_end >= NW'(CB))) begin
        scan_height <= '0;
        scan_side   <= !scan_side;
        if (scan_side) begin
          scan_column <= scan_column + NW'(1);
        end
      end else if (cmd.emit_rect) begin
        scan_height <= height_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find_latch) begin
      hpos <= CW'(scan_height + low_zeros(rest));
      hold <= rd_word;
    end
    if (cmd.run_latch) begin
      run     <= run_low << hpos;
      count   <= low_zeros(~run_src);
      width   <= NW'(1);
      ext_col <= scan_column[CW-1:0] + CW'(1);
    end else if (cmd.absorb) begin
      width   <= width + NW'(1);
      ext_col <= ext_col + CW'(1);
    end
    if (cmd.emit_rect) begin
      result.done_res      <= 1'b0;
      result.is_back       <= scan_side;
      result.width_start   <= scan_column[CW-1:0];
      result.height_start  <= hpos;
      result.height_len    <= count;
      result.width_len     <= width;
      result.flip_diagonal <= (diag_a < diag_b);
    end else if (cmd.emit_done) begin
      result.done_res      <= 1'b1;
      result.is_back       <= 1'b0;
      result.width_start   <= '0;
      result.height_start  <= '0;
      result.height_len    <= '0;
      result.width_len     <= '0;
      result.flip_diagonal <= 1'b0;
    end
  end

endmodule
`default_nettype wire
